>>> sv/altok_pkg.sv
// Shared types and constants for the assembler line tokenizer.
// No dependencies; imported by every module of the block.
package altok_pkg;

    localparam int COL_W   = 12;
    localparam int LINE_W  = 16;
    localparam int COUNT_W = 8;
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);

    localparam logic [COL_W-1:0]   COL_MAX   = {COL_W{1'b1}};
    localparam logic [LINE_W-1:0]  LINE_MAX  = {LINE_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_SEMICOLON = 8'h3B;
    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_NUL       = 8'h00;

    typedef enum logic [1:0] {
        MODE_SEARCH = 2'd0,
        MODE_GRAB   = 2'd1,
        MODE_QUOTE  = 2'd2,
        MODE_IGNORE = 2'd3
    } scan_mode_t;

    typedef enum logic [2:0] {
        KIND_WORD   = 3'd0,
        KIND_COMMA  = 3'd1,
        KIND_STRING = 3'd2,
        KIND_LINE   = 3'd3,
        KIND_ERROR  = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t               kind;
        logic [LINE_W-1:0]   line_number;
        logic [COL_W-1:0]    start_col;
        logic [COL_W-1:0]    end_col;
        logic [COUNT_W-1:0]  token_count;
        logic                last;
    } result_t;

    // up to two results per request, slot 0 first
    typedef struct packed {
        logic [1:0] valid;
        result_t    res1;
        result_t    res0;
    } push_t;

endpackage

>>> sv/altok_scan.sv
// Tokenizer state and per-character mode update; emits up to two results.
// Depends on altok_pkg.
module altok_scan
    import altok_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  ch,
    input  logic        line_end,
    output push_t       push
);

    scan_mode_t         mode_reg, mode_next;
    logic               halted_reg, halted_next;
    logic [COL_W-1:0]   column_reg, column_next;
    logic [COL_W-1:0]   start_reg, start_next;
    logic               bslash_reg, bslash_next;
    logic [LINE_W-1:0]  line_reg, line_next;
    logic [COUNT_W-1:0] tokens_reg, tokens_next;

    logic [COUNT_W-1:0] cnt1, cnt2;
    logic [COL_W-1:0]   word_end, column_inc;
    logic               is_end, blank;
    result_t            r0, r1;
    logic [1:0]         v;

    always_comb
    begin
        cnt1       = (tokens_reg != COUNT_MAX) ? tokens_reg + 1'b1 : tokens_reg;
        cnt2       = (cnt1 != COUNT_MAX) ? cnt1 + 1'b1 : cnt1;
        word_end   = (column_reg > start_reg) ? column_reg - 1'b1 : start_reg;
        column_inc = (column_reg != COL_MAX) ? column_reg + 1'b1 : column_reg;
        is_end     = line_end || (ch == CH_NUL);
        blank      = (ch == CH_SPACE) || (ch == CH_TAB);
    end

    always_comb
    begin
        mode_next   = mode_reg;
        halted_next = halted_reg;
        column_next = column_reg;
        start_next  = start_reg;
        bslash_next = bslash_reg;
        line_next   = line_reg;
        tokens_next = tokens_reg;
        v           = 2'b00;
        r0          = '{kind: KIND_WORD, line_number: line_reg, start_col: start_reg,
                        end_col: word_end, token_count: cnt1, last: 1'b0};
        r1          = '{kind: KIND_COMMA, line_number: line_reg, start_col: column_reg,
                        end_col: column_reg, token_count: cnt2, last: 1'b0};
        if (!halted_reg)
        begin
            if (is_end)
            begin
                if (mode_reg == MODE_QUOTE)
                begin
                    v              = 2'b01;
                    r0.kind        = KIND_ERROR;
                    r0.end_col     = column_reg;
                    r0.token_count = tokens_reg;
                    halted_next    = 1'b1;
                end
                else
                begin
                    if (mode_reg == MODE_GRAB)
                    begin
                        v           = 2'b01;
                        tokens_next = cnt1;
                    end
                    if (line_end)
                    begin
                        // line done goes behind a pending word
                        if (mode_reg == MODE_GRAB)
                        begin
                            v              = 2'b11;
                            r1.kind        = KIND_LINE;
                            r1.start_col   = '0;
                            r1.end_col     = '0;
                            r1.token_count = cnt1;
                        end
                        else
                        begin
                            v              = 2'b01;
                            r0.kind        = KIND_LINE;
                            r0.start_col   = '0;
                            r0.end_col     = '0;
                            r0.token_count = tokens_reg;
                        end
                        mode_next   = MODE_SEARCH;
                        column_next = '0;
                        start_next  = '0;
                        bslash_next = 1'b0;
                        tokens_next = '0;
                        line_next   = (line_reg != LINE_MAX) ? line_reg + 1'b1 : line_reg;
                    end
                    else
                    begin
                        mode_next   = MODE_IGNORE;
                        column_next = column_inc;
                        bslash_next = 1'b0;
                    end
                end
            end
            else
            begin
                case (mode_reg)
                    MODE_SEARCH:
                    begin
                        if (ch == CH_QUOTE)
                        begin
                            start_next = column_reg;
                            mode_next  = MODE_QUOTE;
                        end
                        else if (ch == CH_SEMICOLON)
                        begin
                            mode_next = MODE_IGNORE;
                        end
                        else if (!blank)
                        begin
                            start_next = column_reg;
                            mode_next  = MODE_GRAB;
                        end
                    end
                    MODE_GRAB:
                    begin
                        if (blank)
                        begin
                            v           = 2'b01;
                            tokens_next = cnt1;
                            mode_next   = MODE_SEARCH;
                        end
                        else if (ch == CH_COMMA)
                        begin
                            v           = 2'b11;
                            tokens_next = cnt2;
                            mode_next   = MODE_SEARCH;
                        end
                        else if (ch == CH_SEMICOLON)
                        begin
                            v           = 2'b01;
                            tokens_next = cnt1;
                            mode_next   = MODE_IGNORE;
                        end
                    end
                    MODE_QUOTE:
                    begin
                        // escaped quote stays inside the string
                        if ((ch == CH_QUOTE) && !bslash_reg)
                        begin
                            v           = 2'b01;
                            r0.kind     = KIND_STRING;
                            r0.end_col  = column_reg;
                            tokens_next = cnt1;
                            mode_next   = MODE_SEARCH;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                bslash_next = (ch == CH_BACKSLASH);
                column_next = column_inc;
            end
        end
        r0.last    = !v[1];
        r1.last    = 1'b1;
        push.valid = accept ? v : 2'b00;
        push.res0  = r0;
        push.res1  = r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_SEARCH;
            halted_reg <= 1'b0;
            column_reg <= '0;
            start_reg  <= '0;
            bslash_reg <= 1'b0;
            line_reg   <= {{(LINE_W-1){1'b0}}, 1'b1};
            tokens_reg <= '0;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            halted_reg <= halted_next;
            column_reg <= column_next;
            start_reg  <= start_next;
            bslash_reg <= bslash_next;
            line_reg   <= line_next;
            tokens_reg <= tokens_next;
        end
    end

`ifndef SYNTH
    a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |-> (push.valid == 2'b00))
        else $error("result produced while halted");
    a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        line_reg != '0)
        else $error("line counter reached zero");
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        $past(halted_reg) |-> halted_reg)
        else $error("halt released without reset");
`endif

endmodule

>>> sv/altok_outq.sv
// Four-entry result queue: takes up to two results per cycle, drains one.
// Depends on altok_pkg.
module altok_outq
    import altok_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  push_t    push,
    output logic     room,
    output logic     out_valid,
    input  logic     out_ready,
    output result_t  out_data
);

    result_t             entry_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]     count_reg;
    logic                pop;
    logic [1:0]          n_push;

    assign room      = (count_reg <= (QPTR_W+1)'(QDEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign n_push    = {1'b0, push.valid[0]} + {1'b0, push.valid[1]};

    always_ff @(posedge clk)
    begin
        if (push.valid[0])
            entry_reg[wr_ptr_reg] <= push.res0;
        if (push.valid[1])
            entry_reg[wr_ptr_reg + 1'b1] <= push.res1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + QPTR_W'(n_push);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_reg + (QPTR_W+1)'(n_push) - (QPTR_W+1)'(pop);
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QPTR_W+1)'(QDEPTH))
        else $error("result queue overflow");
    a_push_order: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid[1] |-> push.valid[0])
        else $error("second result without first");
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push.valid != 2'b00) |-> room)
        else $error("push without room");
    a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid[1] |-> (push.res1.last && !push.res0.last))
        else $error("last flag on wrong result");
`endif

endmodule

>>> sv/assembly_line_tokenizer_core.sv
// Top level of the assembler line tokenizer.
// Depends on altok_pkg, altok_scan and altok_outq.
//
// Usage:
//   Slave stream: one source character per request in s_axis_tdata[7:0];
//   s_axis_tlast high marks the end of a line (the byte is then ignored).
//   Master stream: one result per request. tuser carries the kind (word,
//   comma, string, line done, unterminated string error); tdata carries
//   line number, start column, end column and token count; tlast marks
//   the final result caused by one input character.
// A result enters the queue when its character is taken and leaves once
//   earlier results have drained. Throughput: one character per cycle while
//   two entries are free; two results of one character (word plus comma, or
//   word plus line done) leave one at a time by the queue's single port.
// The four-entry result queue accepts a character whenever two entries
//   are free, so s_axis_tready depends only on registered fill level.
// A stalled receiver fills the queue and then drops s_axis_tready; no
//   result is lost. An unterminated string emits one error and halts the
//   block: later characters are taken and produce nothing until reset.
// Reset (rst_n low, asynchronous) empties the queue, sets the line
//   number to 1 and the scanner to search mode.
module assembly_line_tokenizer_core
    import altok_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] ch
    input  logic        s_axis_tlast,   // line_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [15:0] line_number, [27:16] start_col,
                                        // [39:28] end_col, [47:40] token_count
    output logic [2:0]  m_axis_tuser,   // [2:0] kind
    output logic        m_axis_tlast    // last
);

    push_t   push;
    result_t head;
    logic    room;
    logic    accept;

    assign s_axis_tready = room;
    assign accept        = s_axis_tvalid && room;

    altok_scan u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .ch       (s_axis_tdata),
        .line_end (s_axis_tlast),
        .push     (push)
    );

    altok_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (head)
    );

    assign m_axis_tdata = {head.token_count, head.end_col, head.start_col, head.line_number};
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.last;

endmodule
